/* rtl/soa_pkg.sv */
// Shared types and codes for the shadowed output allocator.
package soa_pkg;

  localparam logic [2:0] FUNC_SET      = 3'd0;
  localparam logic [2:0] FUNC_ASSERT   = 3'd1;
  localparam logic [2:0] FUNC_TOGGLE   = 3'd2;
  localparam logic [2:0] FUNC_ALLOCATE = 3'd3;
  localparam logic [2:0] FUNC_NEXT     = 3'd4;
  localparam logic [2:0] FUNC_REINIT   = 3'd5;

  localparam logic CFG_HAS_PLATFORM   = 1'b0;
  localparam logic CFG_SHADOW_DEFAULT = 1'b1;

  typedef struct packed {
    logic latch;
    logic decode;
    logic shd;
    logic nxt;
    logic walk;
    logic unl;
    logic fin;
    logic load_out;
  } soa_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       dev_ok;
    logic       alloc_ok;
    logic       nxt_zero;
    logic       nxt_hit;
    logic       steps_max;
  } soa_stat_t;

endpackage

/* rtl/soa_ctrl.sv */
// Controller state machine for the shadowed output allocator.
module soa_ctrl import soa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  soa_stat_t stat,
  output soa_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SHD  = 3'd2;
  localparam logic [2:0] S_NXT  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_UNL  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        if (stat.func == FUNC_SET || stat.func == FUNC_ASSERT ||
            stat.func == FUNC_TOGGLE) begin
          state_nxt = stat.dev_ok ? S_SHD : S_OUT;
        end else if (stat.func == FUNC_NEXT) begin
          state_nxt = stat.dev_ok ? S_NXT : S_OUT;
        end else if (stat.func == FUNC_ALLOCATE) begin
          state_nxt = stat.alloc_ok ? S_WALK : S_OUT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SHD: begin
        cmd.shd   = 1'b1;
        state_nxt = S_OUT;
      end
      S_NXT: begin
        cmd.nxt   = 1'b1;
        state_nxt = S_OUT;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        priority if (stat.nxt_zero) begin
          state_nxt = S_OUT;
        end else if (stat.nxt_hit) begin
          state_nxt = S_UNL;
        end else if (stat.steps_max) begin
          state_nxt = S_OUT;
        end
      end
      S_UNL: begin
        cmd.unl   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/soa_dp.sv */
// Datapath of the shadowed output allocator: item registers, tables and results.
module soa_dp import soa_pkg::*; #(
  parameter int NUM_OUTPUTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [23:0] in_tdata,
  input  logic [2:0]  in_tuser,
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  soa_cmd_t    cmd,
  output soa_stat_t   stat
);

  localparam int IW = $clog2(NUM_OUTPUTS);
  localparam int SW = $clog2(NUM_OUTPUTS + 1);
  localparam logic [7:0]  N8   = 8'(NUM_OUTPUTS);
  localparam logic [IW:0] NW   = (IW + 1)'(NUM_OUTPUTS);
  localparam logic [SW-1:0] NS = SW'(NUM_OUTPUTS);

  logic [2:0]  func_r;
  logic [7:0]  dev_r, val_r, tail_r;
  logic [IW-1:0] cur_r;
  logic [SW-1:0] steps_r;
  logic        plat_r, plat_nxt;
  logic [7:0]  sdef_r, sdef_nxt;
  logic [7:0]  dflt_r;

  logic [7:0]    shd_mem [NUM_OUTPUTS];
  logic [IW-1:0] lnk_mem [NUM_OUTPUTS];
  logic [NUM_OUTPUTS-1:0] svld_r, lvld_r;

  logic [7:0]    srd_r;
  logic          srv_r;
  logic [IW-1:0] lrd_r, lra_r;
  logic          lrv_r;

  logic        rdv_r, rok_r;
  logic [7:0]  rdd_r, rdval_r, rnx_r;
  logic [31:0] out_tdata_r;

  logic [IW-1:0] dev_idx, lnk_eff, lnk_dflt, l_ra, lw_addr, lw_data;
  logic [IW:0]   lra_inc;
  logic [7:0]    shd_eff, w_val, sw_data;
  logic          sw_en, lw_en;

  assign dev_idx  = dev_r[IW-1:0];
  assign lra_inc  = (IW + 1)'({1'b0, lra_r}) + (IW + 1)'(1);
  assign lnk_dflt = (lra_inc == NW) ? '0 : lra_inc[IW-1:0];
  assign lnk_eff  = lrv_r ? lrd_r : lnk_dflt;
  assign shd_eff  = srv_r ? srd_r : dflt_r;

  assign stat.func      = func_r;
  assign stat.dev_ok    = (dev_r < N8);
  assign stat.alloc_ok  = (dev_r != 8'd0) && (dev_r < N8) && (tail_r < N8);
  assign stat.nxt_zero  = (lnk_eff == '0);
  assign stat.nxt_hit   = (lnk_eff == dev_idx);
  assign stat.steps_max = (steps_r >= NS);

  always_comb begin
    unique case (func_r)
      FUNC_SET:    w_val = val_r;
      FUNC_ASSERT: w_val = shd_eff;
      default:     w_val = (shd_eff != 8'd0) ? 8'd0 : 8'd1;
    endcase
  end

  always_comb begin
    l_ra = dev_idx;
    if (cmd.decode && func_r == FUNC_ALLOCATE) begin
      l_ra = '0;
    end else if (cmd.walk && !stat.nxt_hit) begin
      l_ra = lnk_eff;
    end
  end

  assign sw_en   = cmd.shd || cmd.fin;
  assign sw_data = cmd.fin ? val_r : w_val;
  assign lw_en   = cmd.unl || cmd.fin;
  assign lw_addr = cmd.unl ? cur_r : dev_idx;
  assign lw_data = cmd.unl ? lnk_eff : tail_r[IW-1:0];

  always_comb begin
    plat_nxt = plat_r;
    sdef_nxt = sdef_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_HAS_PLATFORM:   plat_nxt = cfg_wdata[0];
        CFG_SHADOW_DEFAULT: sdef_nxt = cfg_wdata;
        default:            plat_nxt = plat_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plat_r <= 1'b1;
      sdef_r <= 8'd0;
      dflt_r <= 8'd0;
      svld_r <= '0;
      lvld_r <= '0;
    end else begin
      plat_r <= plat_nxt;
      sdef_r <= sdef_nxt;
      if (cmd.decode && func_r == FUNC_REINIT) begin
        dflt_r <= sdef_r;
        svld_r <= '0;
        lvld_r <= '0;
      end else begin
        if (sw_en) svld_r[dev_idx] <= 1'b1;
        if (lw_en) lvld_r[lw_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sw_en) shd_mem[dev_idx] <= sw_data;
    if (lw_en) lnk_mem[lw_addr] <= lw_data;
    srd_r <= shd_mem[dev_idx];
    srv_r <= svld_r[dev_idx];
    lrd_r <= lnk_mem[l_ra];
    lrv_r <= lvld_r[l_ra];
    lra_r <= l_ra;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_tuser;
      dev_r  <= in_tdata[7:0];
      val_r  <= in_tdata[15:8];
      tail_r <= in_tdata[23:16];
    end
    if (cmd.decode) begin
      cur_r   <= '0;
      steps_r <= '0;
      rdv_r   <= 1'b0;
      rdd_r   <= 8'd0;
      rdval_r <= 8'd0;
      rnx_r   <= 8'd0;
      rok_r   <= (func_r == FUNC_REINIT);
    end
    if (cmd.walk && !stat.nxt_zero && !stat.nxt_hit && !stat.steps_max) begin
      cur_r   <= lnk_eff;
      steps_r <= steps_r + SW'(1);
    end
    if (cmd.shd) begin
      rdv_r   <= plat_r;
      rdd_r   <= plat_r ? dev_r : 8'd0;
      rdval_r <= plat_r ? w_val : 8'd0;
      rok_r   <= 1'b1;
    end
    if (cmd.nxt) begin
      rnx_r <= 8'(lnk_eff);
      rok_r <= 1'b1;
    end
    if (cmd.fin) begin
      rok_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_tdata_r <= {6'd0, rnx_r, rok_r, rdval_r, rdd_r, rdv_r};
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

/* rtl/shadowed_output_allocator.sv */
// In-range set, assert and toggle pass decode, shadow and output states; in-range next
// passes decode, next and output; reinit, unknown codes and items rejected at decode go
// straight to output. Allocate walks the free list (at most NUM_OUTPUTS links stepped
// over; the link table gives one read per cycle), then on success unlinks and finishes.
// One item is in work at a time; the next is accepted only after the result is loaded.
// Reset and reinit clear the table valid bits, so entries read as initial values.
module shadowed_output_allocator import soa_pkg::*; #(
  parameter int NUM_OUTPUTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // device[7:0], value[15:8], tail[23:16]
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // drive_valid[0], drive_device[8:1], drive_value[16:9],
                                  // ok[17], link_out[25:18], zero fill[31:26]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  soa_cmd_t  cmd;
  soa_stat_t stat;

  soa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  soa_dp #(
    .NUM_OUTPUTS (NUM_OUTPUTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* bench/soa_bench_pkg.sv */
// Scoreboard class that predicts and checks the shadowed output allocator results.
package soa_bench_pkg;
  import soa_pkg::*;

  localparam int NUM_OUTPUTS = 16;

  typedef struct packed {
    logic [5:0] fill;
    logic [7:0] link_out;
    logic       ok;
    logic [7:0] drive_value;
    logic [7:0] drive_device;
    logic       drive_valid;
  } drive_result_t;

  class output_table_scoreboard;
    logic                has_platform;
    logic [7:0]          shadow_default;
    logic [7:0]          shadow_tbl[NUM_OUTPUTS];
    logic [3:0]          link_tbl[NUM_OUTPUTS];
    drive_result_t       expected_q[$];
    int                  mismatches;
    int                  results_seen;
    int                  items_seen;
    int                  allocs_won;

    function new();
      has_platform   = 1'b1;
      shadow_default = 8'h00;
      mismatches     = 0;
      results_seen   = 0;
      items_seen     = 0;
      allocs_won     = 0;
      reload_table();
    endfunction

    function void reload_table();
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        shadow_tbl[i] = shadow_default;
        link_tbl[i]   = (i + 1 < NUM_OUTPUTS) ? 4'(i + 1) : 4'd0;
      end
    endfunction

    function void write_reg(logic idx, logic [7:0] data);
      if (idx == CFG_HAS_PLATFORM) begin
        has_platform = data[0];
      end else begin
        shadow_default = data;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Returns a random entry currently on the free list, or any nonzero entry if it is empty.
    function logic [7:0] pick_free();
      logic [7:0] nodes[$];
      int         cur;
      cur = link_tbl[0];
      for (int n = 0; n < NUM_OUTPUTS && cur != 0; n++) begin
        nodes.push_back(8'(cur));
        cur = link_tbl[cur];
      end
      if (nodes.size() == 0) return 8'($urandom_range(1, NUM_OUTPUTS - 1));
      return nodes[$urandom_range(0, nodes.size() - 1)];
    endfunction

    function bit try_allocate(logic [7:0] dev, logic [7:0] tail, logic [7:0] init);
      int cur;
      int nxt;
      int steps;
      if (dev == 0 || dev >= NUM_OUTPUTS || tail >= NUM_OUTPUTS) return 1'b0;
      cur   = 0;
      nxt   = link_tbl[0];
      steps = 0;
      while (nxt != 0 && nxt != dev) begin
        if (steps >= NUM_OUTPUTS || nxt >= NUM_OUTPUTS) return 1'b0;
        cur = nxt;
        nxt = link_tbl[cur];
        steps++;
      end
      if (nxt == 0) return 1'b0;
      link_tbl[cur]   = link_tbl[dev];
      link_tbl[dev]   = tail[3:0];
      shadow_tbl[dev] = init;
      return 1'b1;
    endfunction

    function void note_item(logic [2:0] func, logic [7:0] dev, logic [7:0] val,
                            logic [7:0] tail);
      drive_result_t r;
      logic [7:0]    w;
      bit            in_range;
      r        = '0;
      in_range = dev < NUM_OUTPUTS;
      items_seen++;
      case (func)
        FUNC_SET, FUNC_ASSERT, FUNC_TOGGLE: begin
          if (in_range) begin
            if (func == FUNC_SET) begin
              w = val;
            end else if (func == FUNC_ASSERT) begin
              w = shadow_tbl[dev];
            end else begin
              w = (shadow_tbl[dev] != 8'h00) ? 8'h00 : 8'h01;
            end
            shadow_tbl[dev] = w;
            if (has_platform) begin
              r.drive_valid  = 1'b1;
              r.drive_device = dev;
              r.drive_value  = w;
            end
            r.ok = 1'b1;
          end
        end
        FUNC_ALLOCATE: begin
          r.ok = try_allocate(dev, tail, val);
          if (r.ok) allocs_won++;
        end
        FUNC_NEXT: begin
          if (in_range) begin
            r.link_out = {4'h0, link_tbl[dev]};
            r.ok       = 1'b1;
          end
        end
        FUNC_REINIT: begin
          reload_table();
          r.ok = 1'b1;
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(drive_result_t got);
      drive_result_t exp;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d arrived with nothing expected (%h)", results_seen, got);
        return;
      end
      exp = expected_q.pop_front();
      if (got.drive_valid !== exp.drive_valid || got.drive_device !== exp.drive_device ||
          got.drive_value !== exp.drive_value || got.ok !== exp.ok ||
          got.link_out !== exp.link_out || got.fill !== exp.fill) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d expected drv=%0b dev=%0d val=%h ok=%0b next=%0d fill=%h",
                   results_seen, exp.drive_valid, exp.drive_device, exp.drive_value, exp.ok,
                   exp.link_out, exp.fill);
          $display("       result %0d got      drv=%0b dev=%0d val=%h ok=%0b next=%0d fill=%h",
                   results_seen, got.drive_valid, got.drive_device, got.drive_value, got.ok,
                   got.link_out, got.fill);
        end
      end
    endfunction
  endclass

endpackage

/* bench/shadowed_output_allocator_tb.sv */
// Top-level testbench for the shadowed output allocator with random and directed items.
module shadowed_output_allocator_tb import soa_pkg::*, soa_bench_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [7:0]  cfg_wdata  = '0;

  output_table_scoreboard sb;
  bit                     quiet = 1'b0;
  int                     settings_run = 1;

  shadowed_output_allocator #(.NUM_OUTPUTS(NUM_OUTPUTS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(drive_result_t'(out_tdata));
  end

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [2:0] func, logic [7:0] dev, logic [7:0] val,
                           logic [7:0] tail);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {tail, val, dev};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(func, dev, val, tail);
  endtask

  task automatic sender_gap();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 18)) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned sel;
    logic [2:0]  f;
    logic [7:0]  d;
    logic [7:0]  v;
    logic [7:0]  t;
    sel = $urandom_range(0, 99);
    v   = 8'($urandom());
    d   = 8'($urandom_range(0, NUM_OUTPUTS - 1));
    t   = 8'($urandom_range(0, NUM_OUTPUTS - 1));
    if (sel < 12) begin
      f = FUNC_SET;
    end else if (sel < 20) begin
      f = FUNC_ASSERT;
    end else if (sel < 30) begin
      f = FUNC_TOGGLE;
    end else if (sel < 55) begin
      f = FUNC_ALLOCATE;
      if ($urandom_range(0, 3) != 0) d = sb.pick_free();
    end else if (sel < 75) begin
      f = FUNC_NEXT;
    end else if (sel < 79) begin
      f = FUNC_REINIT;
    end else if (sel < 87) begin
      f = 3'($urandom_range(FUNC_SET, FUNC_NEXT));
      d = 8'($urandom_range(NUM_OUTPUTS, 255));
      t = 8'($urandom());
    end else if (sel < 94) begin
      f = 3'($urandom());
      d = 8'($urandom());
      t = 8'($urandom());
    end else begin
      f = ($urandom_range(0, 1) != 0) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
      d = 8'($urandom());
      t = 8'($urandom());
    end
    if (!quiet && $urandom_range(0, 5) == 0) sender_gap();
    send_item(f, d, v, t);
  endtask

  task automatic run_setting(logic platform, logic [7:0] dflt, bit reinit_first, int count,
                             bit hold_mid);
    drain();
    write_reg(CFG_HAS_PLATFORM, {7'($urandom()), platform});
    write_reg(CFG_SHADOW_DEFAULT, dflt);
    settings_run++;
    if (reinit_first) send_item(FUNC_REINIT, 8'($urandom()), 8'($urandom()), 8'($urandom()));
    for (int i = 0; i < count; i++) begin
      if (hold_mid && i == count / 2) drain();
      random_item();
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(FUNC_NEXT, 8'd0, 8'h00, 8'h00);
    send_item(FUNC_NEXT, 8'd15, 8'hFF, 8'hFF);
    send_item(FUNC_NEXT, 8'd16, 8'h00, 8'h00);
    send_item(FUNC_NEXT, 8'd255, 8'hFF, 8'hFF);
    send_item(FUNC_SET, 8'd0, 8'hFF, 8'h00);
    send_item(FUNC_SET, 8'd15, 8'hA5, 8'hFF);
    send_item(FUNC_SET, 8'd16, 8'h01, 8'h00);
    send_item(FUNC_ASSERT, 8'd15, 8'h00, 8'h00);
    send_item(FUNC_TOGGLE, 8'd15, 8'h00, 8'h00);
    send_item(FUNC_TOGGLE, 8'd15, 8'h00, 8'h00);
    send_item(FUNC_TOGGLE, 8'd0, 8'h00, 8'h00);
    send_item(FUNC_ASSERT, 8'd255, 8'h00, 8'h00);
    send_item(FUNC_ALLOCATE, 8'd0, 8'h11, 8'd5);
    send_item(FUNC_ALLOCATE, 8'd16, 8'h11, 8'd5);
    send_item(FUNC_ALLOCATE, 8'd3, 8'h11, 8'd16);
    send_item(FUNC_ALLOCATE, 8'd3, 8'h5A, 8'd15);
    send_item(FUNC_ALLOCATE, 8'd3, 8'h5A, 8'd15);
    send_item(FUNC_NEXT, 8'd3, 8'h00, 8'h00);
    send_item(FUNC_ALLOCATE, 8'd15, 8'hFF, 8'd0);
    send_item(FUNC_ALLOCATE, 8'd1, 8'h00, 8'd1);
    send_item(FUNC_SPARE_LO, 8'hFF, 8'hFF, 8'hFF);
    send_item(FUNC_SPARE_HI, 8'hAA, 8'h55, 8'hAA);
    send_item(FUNC_REINIT, 8'h00, 8'h00, 8'h00);
    send_item(FUNC_NEXT, 8'd2, 8'h00, 8'h00);

    for (int i = 0; i < 180; i++) random_item();
    run_setting(1'b0, 8'hFF, 1'b1, 190, 1'b0);
    run_setting(1'b1, 8'($urandom_range(1, 254)), 1'b0, 190, 1'b1);
    quiet = 1'b1;
    run_setting(1'b1, 8'h00, 1'b1, 190, 1'b0);

    drain();
    repeat (40) @(posedge clk);
    $display("Run covered %0d items under %0d register settings, %0d allocates succeeded.",
             sb.items_seen, settings_run, sb.allocs_won);
    $display("%0d results checked, %0d mismatches.", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
